/* rtl/wmss_pkg.sv */
package wmss_pkg;

   localparam int HEADER_LEN   = 8;
   localparam int LEB_LAST_IDX = 4;
   localparam int MEMORY_SECTION_ID = 5;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_INVALID   = 2'd2
   } status_type;

   typedef enum logic [8:0] {
      PH_MAGIC   = 9'b000000001,
      PH_SEC_ID  = 9'b000000010,
      PH_SEC_LEN = 9'b000000100,
      PH_SKIP    = 9'b000001000,
      PH_COUNT   = 9'b000010000,
      PH_FLAGS   = 9'b000100000,
      PH_MIN     = 9'b001000000,
      PH_MAX     = 9'b010000000,
      PH_DONE    = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [31:0] buffer_length;
      logic        last_byte;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] min_page_count;
      logic        has_max;
      logic [31:0] max_page_count;
   } rsp_payload_type;

   function automatic logic [7:0] header_byte(input logic [2:0] idx);
      logic [7:0] value;
      unique case (idx)
         3'd1: value = 8'h61;
         3'd2: value = 8'h73;
         3'd3: value = 8'h6d;
         3'd4: value = 8'h01;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

   // Bits that land above bit 31 are dropped.
   function automatic logic [31:0] leb_merge(input logic [31:0] acc, input logic [2:0] idx,
                                             input logic [7:0] data);
      logic [31:0] part;
      logic [31:0] value;
      part = {25'd0, data[6:0]};
      unique case (idx)
         3'd0: value = acc | part;
         3'd1: value = acc | (part << 7);
         3'd2: value = acc | (part << 14);
         3'd3: value = acc | (part << 21);
         3'd4: value = acc | (part << 28);
         default: value = acc;
      endcase
      return value;
   endfunction

endpackage

/* rtl/wmss_if.sv */
interface wmss_req_if;
   import wmss_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface wmss_rsp_if;
   import wmss_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/wmss_parser.sv */
module wmss_parser #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [7:0]               data_byte,
   input  logic [31:0]              buffer_length,
   input  logic                     last_byte,
   output logic                     result_valid,
   output wmss_pkg::rsp_payload_type result
);
   import wmss_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [31:0]            leb_ff, leb_in;
   logic [2:0]             leb_idx_ff, leb_idx_in;
   logic [7:0]             sec_id_ff, sec_id_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [31:0]            init_ff, init_in;
   logic                   max_flag_ff, max_flag_in;

   logic [LENGTH_BITS-1:0] len;
   logic [LENGTH_BITS:0]   pos_next;
   logic [LENGTH_BITS-1:0] left;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic [31:0]            leb_full;
   logic                   leb_done;
   logic                   leb_bad;
   logic                   at_end;
   logic                   pos_last;
   logic                   settle;
   rsp_payload_type        res;

   assign len      = buffer_length[LENGTH_BITS-1:0];
   assign pos_next = {1'b0, pos_ff} + 1'b1;
   assign left     = len - pos_next[LENGTH_BITS-1:0];
   assign rem_dec  = rem_ff - 1'b1;
   assign leb_full = leb_merge(leb_ff, leb_idx_ff, data_byte);
   assign leb_done = !data_byte[7];
   assign leb_bad  = data_byte[7] && (leb_idx_ff == 3'(LEB_LAST_IDX));
   assign at_end   = pos_ff >= len;
   assign pos_last = pos_next == {1'b0, len};

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      leb_in      = leb_ff;
      leb_idx_in  = leb_idx_ff;
      sec_id_in   = sec_id_ff;
      rem_in      = rem_ff;
      init_in     = init_ff;
      max_flag_in = max_flag_ff;
      settle      = 1'b0;
      res         = '0;
      res.status  = STATUS_INVALID;
      if (fire) begin
         if (phase_ff != PH_DONE) begin
            if (at_end) begin
               settle     = 1'b1;
               res.status = (phase_ff == PH_SEC_ID) ? STATUS_NOT_FOUND : STATUS_INVALID;
            end else begin
               unique case (phase_ff)
                  PH_MAGIC: begin
                     if (len < LENGTH_BITS'(HEADER_LEN) ||
                         data_byte != header_byte(pos_ff[2:0])) begin
                        settle = 1'b1;
                     end else if (pos_ff == LENGTH_BITS'(HEADER_LEN - 1)) begin
                        phase_in = PH_SEC_ID;
                     end
                  end
                  PH_SEC_ID: begin
                     sec_id_in  = data_byte;
                     leb_in     = '0;
                     leb_idx_in = '0;
                     phase_in   = PH_SEC_LEN;
                  end
                  PH_SEC_LEN: begin
                     if (leb_bad) begin
                        settle = 1'b1;
                     end else if (!leb_done) begin
                        leb_in     = leb_full;
                        leb_idx_in = leb_idx_ff + 1'b1;
                     end else if (leb_full > 32'(left)) begin
                        settle     = 1'b1;
                        res.status = (sec_id_ff < 8'(MEMORY_SECTION_ID)) ?
                                     STATUS_NOT_FOUND : STATUS_INVALID;
                     end else if (sec_id_ff == 8'(MEMORY_SECTION_ID)) begin
                        if (leb_full == '0) begin
                           settle = 1'b1;
                        end else begin
                           rem_in     = LENGTH_BITS'(leb_full);
                           leb_in     = '0;
                           leb_idx_in = '0;
                           phase_in   = PH_COUNT;
                        end
                     end else if (sec_id_ff > 8'(MEMORY_SECTION_ID)) begin
                        settle     = 1'b1;
                        res.status = STATUS_NOT_FOUND;
                     end else begin
                        rem_in   = LENGTH_BITS'(leb_full);
                        phase_in = (leb_full == '0) ? PH_SEC_ID : PH_SKIP;
                     end
                  end
                  PH_SKIP: begin
                     rem_in = rem_dec;
                     if (rem_dec == '0) begin
                        phase_in = PH_SEC_ID;
                     end
                  end
                  PH_FLAGS: begin
                     rem_in      = rem_dec;
                     max_flag_in = data_byte[0];
                     if (rem_dec == '0) begin
                        settle = 1'b1;
                     end else begin
                        leb_in     = '0;
                        leb_idx_in = '0;
                        phase_in   = PH_MIN;
                     end
                  end
                  PH_COUNT, PH_MIN, PH_MAX: begin
                     rem_in = rem_dec;
                     if (leb_bad) begin
                        settle = 1'b1;
                     end else if (!leb_done) begin
                        if (rem_dec == '0) begin
                           settle = 1'b1;
                        end else begin
                           leb_in     = leb_full;
                           leb_idx_in = leb_idx_ff + 1'b1;
                        end
                     end else if (phase_ff == PH_COUNT) begin
                        if (leb_full == '0) begin
                           settle     = 1'b1;
                           res.status = STATUS_NOT_FOUND;
                        end else if (rem_dec == '0) begin
                           settle = 1'b1;
                        end else begin
                           phase_in = PH_FLAGS;
                        end
                     end else if (phase_ff == PH_MIN) begin
                        init_in = leb_full;
                        if (!max_flag_ff) begin
                           settle             = 1'b1;
                           res.status         = STATUS_OK;
                           res.min_page_count = leb_full;
                        end else if (rem_dec == '0) begin
                           settle = 1'b1;
                        end else begin
                           leb_in     = '0;
                           leb_idx_in = '0;
                           phase_in   = PH_MAX;
                        end
                     end else begin
                        settle             = 1'b1;
                        res.status         = STATUS_OK;
                        res.min_page_count = init_ff;
                        res.has_max        = 1'b1;
                        res.max_page_count = leb_full;
                     end
                  end
                  default: begin
                  end
               endcase
               if (!settle && pos_last) begin
                  settle     = 1'b1;
                  res.status = (phase_in == PH_SEC_ID) ? STATUS_NOT_FOUND : STATUS_INVALID;
               end
            end
            if (settle) begin
               phase_in = PH_DONE;
            end
         end
         if (pos_ff != '1) begin
            pos_in = pos_next[LENGTH_BITS-1:0];
         end
         if (last_byte) begin
            if (!settle && phase_ff != PH_DONE) begin
               settle     = 1'b1;
               res        = '0;
               res.status = STATUS_INVALID;
            end
            phase_in    = PH_MAGIC;
            pos_in      = '0;
            leb_in      = '0;
            leb_idx_in  = '0;
            sec_id_in   = '0;
            rem_in      = '0;
            init_in     = '0;
            max_flag_in = 1'b0;
         end
      end
   end

   assign result_valid = settle;
   assign result       = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MAGIC;
         pos_ff      <= '0;
         leb_ff      <= '0;
         leb_idx_ff  <= '0;
         sec_id_ff   <= '0;
         rem_ff      <= '0;
         init_ff     <= '0;
         max_flag_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         leb_ff      <= leb_in;
         leb_idx_ff  <= leb_idx_in;
         sec_id_ff   <= sec_id_in;
         rem_ff      <= rem_in;
         init_ff     <= init_in;
         max_flag_ff <= max_flag_in;
      end
   end

endmodule

/* rtl/wasm_memory_section_scanner.sv */
// A result is registered and presented in the cycle after the request that settles it is accepted.
// Throughput: one byte per cycle while no waiting result is held back; the parser updates its state per byte.
// A waiting result stalls new requests only while the response side holds it back.
// Reset is synchronous and active high; it returns the parser to the header check
// and empties the result register.
module wasm_memory_section_scanner #(
   parameter int LENGTH_BITS = 32
) (
   input logic         clock,
   input logic         reset,
   wmss_req_if.sink    req_chan,
   wmss_rsp_if.source  rsp_chan
);
   import wmss_pkg::*;

   logic            req_fire;
   logic            result_valid;
   rsp_payload_type result;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   wmss_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .fire          (req_fire),
      .data_byte     (req_chan.payload.data_byte),
      .buffer_length (req_chan.payload.buffer_length),
      .last_byte     (req_chan.payload.last_byte),
      .result_valid  (result_valid),
      .result        (result)
   );

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire && result_valid) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule
